>>> rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SHD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SHD_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHD_ASSERT(lbl, clk, rstn, prop, msg)
`define SHD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/core/shd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Shader package
// Shared types and constants of the Phong shading pipeline.
// ---------------------------------------------------------------------------
package shd_pkg;

    localparam logic [15:0] AMB_Q16     = 16'd6554;
    localparam logic [15:0] DIFSPEC_Q16 = 16'd58982;
    localparam logic [14:0] ONE_Q14     = 15'd16384;

    typedef logic [2:0][15:0] t_mag3;

    // one step of the square root: remaining radicand, remainder, partial root
    typedef struct packed {
        logic [31:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
        t_mag3       mag;
        logic [2:0]  neg;
    } t_sqrt_st;

    // one step of the three component divisions
    typedef struct packed {
        logic [31:0]       den;
        logic [2:0][45:0]  num;
        logic [2:0][14:0]  quo;
        logic [2:0]        neg;
        logic              zero;
    } t_div_st;

    typedef enum logic [2:0] {
        CFG_LDIR_X = 3'd0,
        CFG_LDIR_Y = 3'd1,
        CFG_LDIR_Z = 3'd2,
        CFG_LRGB   = 3'd3,
        CFG_EYE_X  = 3'd4,
        CFG_EYE_Y  = 3'd5,
        CFG_EYE_Z  = 3'd6
    } t_cfg_idx;

endpackage

>>> rtl/core/shd_norm.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vector normaliser
// Pipelined normalise of a signed 3-vector to Q1.14: range reduce, sum of
// squares, one root bit per stage, one quotient bit per stage.
// ---------------------------------------------------------------------------
module shd_norm import shd_pkg::*; #(
    parameter int W  = 17,
    parameter int PW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [2:0][W-1:0]    i_vec,
    input  logic [PW-1:0]        i_side,
    output logic                 o_valid,
    output logic [2:0][15:0]     o_vec,
    output logic [PW-1:0]        o_side
);

    localparam int KMAX      = W - 16;
    localparam int KB        = (KMAX > 1) ? $clog2(KMAX + 1) : 1;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 15;
    localparam int LAT       = 6 + SQ_STEPS + 1 + DIV_STEPS + 1;
    localparam logic [W-1:0] LIM = W'(32768);

    function automatic t_sqrt_st f_sqrt_step(t_sqrt_st s);
        t_sqrt_st    o;
        logic [34:0] tmp;
        logic [34:0] trial;
        o     = s;
        tmp   = {s.rem[32:0], s.rad[31:30]};
        trial = {1'b0, s.root, 2'b01};
        o.rad = {s.rad[29:0], 2'b00};
        if (tmp >= trial) begin
            o.rem  = tmp - trial;
            o.root = {s.root[30:0], 1'b1};
        end else begin
            o.rem  = tmp;
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_div_st f_div_step(t_div_st s, int j);
        t_div_st     o;
        logic [45:0] dsh;
        o   = s;
        dsh = {14'b0, s.den} << j;
        for (int i = 0; i < 3; i++) begin
            if (s.num[i] >= dsh) begin
                o.num[i] = s.num[i] - dsh;
                o.quo[i] = s.quo[i] | (15'd1 << j);
            end
        end
        return o;
    endfunction

    logic [2:0][W-1:0]  r_s1_mag;
    logic [2:0]         r_s1_neg;
    logic [2:0][W-1:0]  r_s2_mag;
    logic [2:0]         r_s2_neg;
    logic [W-1:0]       r_s2_max;
    logic [W-1:0]       s2_m01;
    logic [2:0][W-1:0]  r_s3_mag;
    logic [2:0]         r_s3_neg;
    logic [KB-1:0]      r_s3_k;
    logic [KB-1:0]      s3_k;
    t_mag3              r_s4_mag;
    logic [2:0]         r_s4_neg;
    logic [2:0][31:0]   r_s5_sq;
    t_mag3              r_s5_mag;
    logic [2:0]         r_s5_neg;
    logic [31:0]        r_s6_sum;
    t_mag3              r_s6_mag;
    logic [2:0]         r_s6_neg;
    t_sqrt_st           sq_init;
    t_sqrt_st           r_sq [0:SQ_STEPS-1];
    t_div_st            r_dv [0:DIV_STEPS];
    logic [2:0][15:0]   r_out;
    logic [LAT-1:0]     r_vld;
    logic [LAT-1:0][PW-1:0] r_side;

    // range reduce: magnitudes, largest one, shift that brings it to at most 2^15
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_s1_neg[i] <= i_vec[i][W-1];
                r_s1_mag[i] <= i_vec[i][W-1] ? W'(-i_vec[i]) : i_vec[i];
            end
        end
    end

    assign s2_m01 = (r_s1_mag[0] > r_s1_mag[1]) ? r_s1_mag[0] : r_s1_mag[1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_mag <= r_s1_mag;
            r_s2_neg <= r_s1_neg;
            r_s2_max <= (s2_m01 > r_s1_mag[2]) ? s2_m01 : r_s1_mag[2];
        end
    end

    always_comb begin
        s3_k = '0;
        for (int k = KMAX; k >= 0; k--) begin
            if ((r_s2_max >> k) <= LIM) begin
                s3_k = KB'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_mag <= r_s2_mag;
            r_s3_neg <= r_s2_neg;
            r_s3_k   <= s3_k;
            for (int i = 0; i < 3; i++) begin
                r_s4_mag[i] <= 16'(r_s3_mag[i] >> r_s3_k);
                r_s5_sq[i]  <= 32'(r_s4_mag[i]) * 32'(r_s4_mag[i]);
            end
            r_s4_neg <= r_s3_neg;
            r_s5_mag <= r_s4_mag;
            r_s5_neg <= r_s4_neg;
            r_s6_sum <= r_s5_sq[0] + r_s5_sq[1] + r_s5_sq[2];
            r_s6_mag <= r_s5_mag;
            r_s6_neg <= r_s5_neg;
        end
    end

    // square root of sum * 2^32, one result bit per stage
    always_comb begin
        sq_init      = '0;
        sq_init.rad  = r_s6_sum;
        sq_init.mag  = r_s6_mag;
        sq_init.neg  = r_s6_neg;
    end

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        if (g == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq[g] <= f_sqrt_step(sq_init);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq[g] <= f_sqrt_step(r_sq[g-1]);
                end
            end
        end
    end

    // set up rounded numerators, then one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0].den  <= r_sq[SQ_STEPS-1].root;
            r_dv[0].neg  <= r_sq[SQ_STEPS-1].neg;
            r_dv[0].zero <= (r_sq[SQ_STEPS-1].root == '0);
            r_dv[0].quo  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_dv[0].num[i] <= {r_sq[SQ_STEPS-1].mag[i], 30'b0}
                                + {15'b0, r_sq[SQ_STEPS-1].root[31:1]};
            end
        end
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[g+1] <= f_div_step(r_dv[g], DIV_STEPS - 1 - g);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dv[DIV_STEPS].zero) begin
                    r_out[i] <= '0;
                end else if (r_dv[DIV_STEPS].quo[i] > ONE_Q14) begin
                    r_out[i] <= r_dv[DIV_STEPS].neg[i] ? 16'(-{1'b0, ONE_Q14})
                                                       : {1'b0, ONE_Q14};
                end else begin
                    r_out[i] <= r_dv[DIV_STEPS].neg[i] ? 16'(-{1'b0, r_dv[DIV_STEPS].quo[i]})
                                                       : {1'b0, r_dv[DIV_STEPS].quo[i]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= {r_side[LAT-2:0], i_side};
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_vec   = r_out;
    assign o_side  = r_side[LAT-1];

endmodule

>>> rtl/core/shd_pow.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Specular power
// Repeated rounded squaring of a Q1.14 factor, one multiply per stage.
// ---------------------------------------------------------------------------
module shd_pow import shd_pkg::*; #(
    parameter int N  = 6,
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [14:0]   i_p,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [14:0]   o_p,
    output logic [PW-1:0] o_side
);

    function automatic logic [14:0] f_sq(logic [14:0] p);
        logic [29:0] s;
        s = 30'(p) * 30'(p) + 30'd8192;
        return s[28:14];
    endfunction

    if (N == 0) begin : g_none
        assign o_valid = i_valid;
        assign o_p     = i_p;
        assign o_side  = i_side;
    end else begin : g_stages
        logic [14:0]   r_p    [0:N-1];
        logic [N-1:0]  r_vld;
        logic [PW-1:0] r_side [0:N-1];

        for (genvar g = 0; g < N; g++) begin : g_sq
            if (g == 0) begin : g_first
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_p[g]    <= f_sq(i_p);
                        r_side[g] <= i_side;
                    end
                end
            end else begin : g_next
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_p[g]    <= f_sq(r_p[g-1]);
                        r_side[g] <= r_side[g-1];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= '0;
            end else if (i_en) begin
                r_vld <= N'({r_vld, i_valid});
            end
        end

        assign o_valid = r_vld[N-1];
        assign o_p     = r_p[N-1];
        assign o_side  = r_side[N-1];
    end

endmodule

>>> rtl/core/phong_directional_light_shader.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Phong directional light shader
// Shades one ray hit per item: ambient, diffuse and specular terms under a
// single directional light, each colour channel saturated at 255.
// ---------------------------------------------------------------------------
// Use: items enter on the s_axis channel (hit position, normal, surface
// colour) and leave on m_axis as one shaded colour each, in order.
// Light direction, light colour and eye position sit in registers written
// through the cfg channel; write them only while the pipeline is empty.
// Throughput: one item per cycle unless m_axis stalls; every stage advances
// together. Pipeline: two normalisers in series of 55 stages each (one root
// bit and one quotient bit per stage), seven dot/reflect stages, the
// squaring chain and three colour stages ending in the output register.
// Stall: while a result waits on m_axis, the whole pipeline holds and
// s_axis_tready drops; nothing is dropped or repeated.
// Reset: clears the valid bits and the configuration registers (all zero).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module phong_directional_light_shader import shd_pkg::*; #(
    parameter int SPEC_EXPONENT_LOG2 = 6
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // hit_x, hit_y, hit_z (32 each), normal_x, normal_y, normal_z (16 each),
    // surf_r, surf_g, surf_b (8 each), lowest bit up
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_r, out_g, out_b (8 each), lowest bit up
    output logic [23:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    // configuration registers
    logic [15:0] r_ldir_x, r_ldir_y, r_ldir_z;
    logic [23:0] r_lrgb;
    logic [31:0] r_eye_x, r_eye_y, r_eye_z;

    logic adv;

    logic [2:0][16:0] nd;
    logic [2:0][32:0] dv;
    logic [2:0][15:0] in_n;
    logic [2:0][7:0]  in_surf;

    logic             l_valid, v_valid, lv_valid;
    logic [2:0][15:0] l_vec, v_vec, n_vec;
    logic [2:0][7:0]  v_surf;

    logic                     r_p1_valid;
    logic [2:0][31:0]         r_p1_prod;
    logic [2:0][15:0]         r_p1_n, r_p1_l, r_p1_v;
    logic [2:0][7:0]          r_p1_surf;
    logic                     r_p2_valid;
    logic signed [33:0]       r_p2_dln;
    logic [2:0][15:0]         r_p2_n, r_p2_l, r_p2_v;
    logic [2:0][7:0]          r_p2_surf;
    logic                     r_p3_valid;
    logic signed [49:0]       r_p3_t [3];
    logic [16:0]              r_p3_ndl;
    logic [2:0][15:0]         r_p3_l, r_p3_v;
    logic [2:0][7:0]          r_p3_surf;
    logic                     r_p4_valid;
    logic [2:0][21:0]         r_p4_r;
    logic [16:0]              r_p4_ndl;
    logic [2:0][15:0]         r_p4_v;
    logic [2:0][7:0]          r_p4_surf;

    logic             rn_valid;
    logic [2:0][15:0] rn_vec;
    logic [88:0]      rn_side;
    logic [2:0][15:0] rn_v;
    logic [16:0]      rn_ndl;
    logic [2:0][7:0]  rn_surf;

    logic                     r_p5_valid;
    logic [2:0][31:0]         r_p5_prod;
    logic [40:0]              r_p5_side;
    logic                     r_p6_valid;
    logic [33:0]              r_p6_rv;
    logic [40:0]              r_p6_side;
    logic                     r_p7_valid;
    logic [14:0]              r_p7_p;
    logic [40:0]              r_p7_side;
    logic [15:0]              p6_rvs;

    logic        pw_valid;
    logic [14:0] pw_p;
    logic [40:0] pw_side;

    logic              r_c1_valid;
    logic [2:0][23:0]  r_c1_lca, r_c1_scd, r_c1_lcd;
    logic [16:0]       r_c1_ndl;
    logic [14:0]       r_c1_p;
    logic              r_c2_valid;
    logic [2:0][37:0]  r_c2_amb;
    logic [2:0][40:0]  r_c2_dif;
    logic [2:0][38:0]  r_c2_spc;
    logic [2:0][42:0]  c3_acc;
    logic              r_out_valid;
    logic [2:0][7:0]   r_out;

    // configuration writes, always taken; unknown index dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ldir_x <= '0;
            r_ldir_y <= '0;
            r_ldir_z <= '0;
            r_lrgb   <= '0;
            r_eye_x  <= '0;
            r_eye_y  <= '0;
            r_eye_z  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LDIR_X: r_ldir_x <= i_cfg_data[15:0];
                CFG_LDIR_Y: r_ldir_y <= i_cfg_data[15:0];
                CFG_LDIR_Z: r_ldir_z <= i_cfg_data[15:0];
                CFG_LRGB:   r_lrgb   <= i_cfg_data[23:0];
                CFG_EYE_X:  r_eye_x  <= i_cfg_data;
                CFG_EYE_Y:  r_eye_y  <= i_cfg_data;
                CFG_EYE_Z:  r_eye_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance every stage unless a finished result is held
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv;

    // negated light direction and hit-to-eye vector
    assign nd[0] = 17'(-{r_ldir_x[15], r_ldir_x});
    assign nd[1] = 17'(-{r_ldir_y[15], r_ldir_y});
    assign nd[2] = 17'(-{r_ldir_z[15], r_ldir_z});
    assign dv[0] = {r_eye_x[31], r_eye_x} - {s_axis_tdata[31], s_axis_tdata[31:0]};
    assign dv[1] = {r_eye_y[31], r_eye_y} - {s_axis_tdata[63], s_axis_tdata[63:32]};
    assign dv[2] = {r_eye_z[31], r_eye_z} - {s_axis_tdata[95], s_axis_tdata[95:64]};
    assign in_n    = s_axis_tdata[143:96];
    assign in_surf = s_axis_tdata[167:144];

    // L and V normalise side by side; N rides with L, surface colour with V
    shd_norm #(.W(17), .PW(48)) u_norm_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (s_axis_tvalid),
        .i_vec   (nd),
        .i_side  (in_n),
        .o_valid (l_valid),
        .o_vec   (l_vec),
        .o_side  (n_vec)
    );

    shd_norm #(.W(33), .PW(24)) u_norm_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (s_axis_tvalid),
        .i_vec   (dv),
        .i_side  (in_surf),
        .o_valid (v_valid),
        .o_vec   (v_vec),
        .o_side  (v_surf)
    );

    assign lv_valid = l_valid & v_valid;

    // N.L, diffuse factor and reflected vector
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_p1_prod[i] <= $signed(l_vec[i]) * $signed(n_vec[i]);
            end
            r_p1_n    <= n_vec;
            r_p1_l    <= l_vec;
            r_p1_v    <= v_vec;
            r_p1_surf <= v_surf;

            r_p2_dln  <= $signed({{2{r_p1_prod[0][31]}}, r_p1_prod[0]})
                       + $signed({{2{r_p1_prod[1][31]}}, r_p1_prod[1]})
                       + $signed({{2{r_p1_prod[2][31]}}, r_p1_prod[2]});
            r_p2_n    <= r_p1_n;
            r_p2_l    <= r_p1_l;
            r_p2_v    <= r_p1_v;
            r_p2_surf <= r_p1_surf;

            for (int i = 0; i < 3; i++) begin
                r_p3_t[i] <= r_p2_dln * $signed(r_p2_n[i]);
            end
            r_p3_ndl  <= (!r_p2_dln[33] && r_p2_dln != '0) ? r_p2_dln[30:14] : '0;
            r_p3_l    <= r_p2_l;
            r_p3_v    <= r_p2_v;
            r_p3_surf <= r_p2_surf;

            // floor(2*t / 2^28) is the arithmetic shift by 27
            for (int i = 0; i < 3; i++) begin
                r_p4_r[i] <= r_p3_t[i][48:27] - {{6{r_p3_l[i][15]}}, r_p3_l[i]};
            end
            r_p4_ndl  <= r_p3_ndl;
            r_p4_v    <= r_p3_v;
            r_p4_surf <= r_p3_surf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
            r_p4_valid <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= lv_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
            r_p4_valid <= r_p3_valid;
        end
    end

    shd_norm #(.W(22), .PW(89)) u_norm_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_p4_valid),
        .i_vec   (r_p4_r),
        .i_side  ({r_p4_surf, r_p4_ndl, r_p4_v}),
        .o_valid (rn_valid),
        .o_vec   (rn_vec),
        .o_side  (rn_side)
    );

    assign rn_v    = rn_side[47:0];
    assign rn_ndl  = rn_side[64:48];
    assign rn_surf = rn_side[88:65];

    // R.V and the clamped specular base
    assign p6_rvs = r_p6_rv[29:14];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_p5_prod[i] <= $signed(rn_vec[i]) * $signed(rn_v[i]);
            end
            r_p5_side <= {rn_surf, rn_ndl};
            r_p6_rv   <= {{2{r_p5_prod[0][31]}}, r_p5_prod[0]}
                       + {{2{r_p5_prod[1][31]}}, r_p5_prod[1]}
                       + {{2{r_p5_prod[2][31]}}, r_p5_prod[2]};
            r_p6_side <= r_p5_side;
            if (r_p6_rv[33] || r_p6_rv == '0) begin
                r_p7_p <= '0;
            end else if (p6_rvs > 16'(ONE_Q14)) begin
                r_p7_p <= ONE_Q14;
            end else begin
                r_p7_p <= p6_rvs[14:0];
            end
            r_p7_side <= r_p6_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_valid <= 1'b0;
            r_p6_valid <= 1'b0;
            r_p7_valid <= 1'b0;
        end else if (adv) begin
            r_p5_valid <= rn_valid;
            r_p6_valid <= r_p5_valid;
            r_p7_valid <= r_p6_valid;
        end
    end

    shd_pow #(.N(SPEC_EXPONENT_LOG2), .PW(41)) u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_p7_valid),
        .i_p     (r_p7_p),
        .i_side  (r_p7_side),
        .o_valid (pw_valid),
        .o_p     (pw_p),
        .o_side  (pw_side)
    );

    // colour: weights, products, then sum, round and saturate
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_c1_lca[i] <= 24'(r_lrgb[23-8*i -: 8]) * 24'(AMB_Q16);
                r_c1_lcd[i] <= 24'(r_lrgb[23-8*i -: 8]) * 24'(DIFSPEC_Q16);
                r_c1_scd[i] <= 24'(pw_side[17+8*i +: 8]) * 24'(DIFSPEC_Q16);
            end
            r_c1_ndl <= pw_side[16:0];
            r_c1_p   <= pw_p;
            for (int i = 0; i < 3; i++) begin
                r_c2_amb[i] <= {r_c1_lca[i], 14'b0};
                r_c2_dif[i] <= r_c1_scd[i] * r_c1_ndl;
                r_c2_spc[i] <= r_c1_lcd[i] * r_c1_p;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c3_acc[i] = 43'(r_c2_amb[i]) + 43'(r_c2_dif[i]) + 43'(r_c2_spc[i])
                      + 43'(30'd536870912);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                r_out[i] <= (|c3_acc[i][42:38]) ? 8'hFF : c3_acc[i][37:30];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_valid  <= 1'b0;
            r_c2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_c1_valid  <= pw_valid;
            r_c2_valid  <= r_c1_valid;
            r_out_valid <= r_c2_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    `SHD_ASSERT(a_stall_holds_input, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready, "input taken while result held")
    `SHD_ASSERT(a_norm_aligned, i_clk, i_rst_n, l_valid == v_valid, "light and view normalisers out of step")
    `SHD_ASSERT(a_spec_base_range, i_clk, i_rst_n, r_p7_valid |-> (r_p7_p <= ONE_Q14), "specular base above one")
    `SHD_ASSERT_NR(a_reset_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule
